// File: hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker of the height scaler.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define STHS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sths_pkg.sv
// Shared types, constants and arithmetic helpers of the height scaler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sths_pkg;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MAG_W       = DATA_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * MAG_W;
  localparam int unsigned SPROD_W     = PROD_W + 1;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned FB_IDX_W    = $clog2(FRAC_BITS);
  localparam int unsigned EXP_N_W     = 8;
  localparam int unsigned MANT_MSB    = 30;

  typedef logic signed [DATA_WIDTH-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam val_t Q_ONE   = val_t'(64'd1 << FRAC_BITS);
  localparam val_t EXP_LIM = val_t'(64'd64 << FRAC_BITS);

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_LOG    = 2'd1;
  localparam logic [1:0] MODE_SKEW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEWLOG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEWGN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd6;

  typedef enum logic [1:0] {
    CLS_PASS = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_LOG  = 2'd2,
    CLS_SKEW = 2'd3
  } cls_e;

  typedef struct packed {
    logic [1:0] scaling_mode;
    val_t       range_low;
    val_t       range_inverse;
    val_t       skew_log;
    val_t       skew_gain;
    val_t       height_gain;
    val_t       height_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample_value;
    logic                         restart;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] height;
    logic signed [DATA_WIDTH-1:0] height_min;
    logic signed [DATA_WIDTH-1:0] height_max;
  } out_item_t;

  typedef struct packed {
    val_t sample;
    logic restart;
    cls_e cls;
  } qent_t;

  typedef struct packed {
    logic [MAG_W-1:0] a_mag;
    logic [MAG_W-1:0] b_mag;
    logic             neg;
  } mul_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              neg;
  } mul_rsp_t;

  typedef logic [FRAC_BITS-1:0][31:0] root_tab_t;

  function automatic logic [MAG_W-1:0] mag(input val_t v);
    logic [MAG_W-1:0] e;
    e = MAG_W'(v);
    return v[DATA_WIDTH-1] ? (MAG_W'(0) - e) : e;
  endfunction

  function automatic mul_req_t sreq(input val_t a, input val_t b);
    mul_req_t r;
    r.a_mag = mag(a);
    r.b_mag = mag(b);
    r.neg   = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    return r;
  endfunction

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? VAL_MIN : VAL_MAX;
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? VAL_MIN : VAL_MAX;
    return s[DATA_WIDTH-1:0];
  endfunction

  // Fixed-point product: truncate toward zero, saturate.
  function automatic val_t mulq(input mul_rsp_t r);
    logic [PROD_W-1:0] q;
    q = r.prod >> FRAC_BITS;
    if (r.neg) begin
      if (q > (PROD_W'(1) << (DATA_WIDTH-1))) return VAL_MIN;
      return val_t'(PROD_W'(0) - q);
    end
    if (q > PROD_W'(VAL_MAX)) return VAL_MAX;
    return val_t'(q);
  endfunction

  function automatic logic signed [SPROD_W-1:0] sprod(input mul_rsp_t r);
    logic [SPROD_W-1:0] e;
    e = {1'b0, r.prod};
    return r.neg ? $signed(SPROD_W'(0) - e) : $signed(e);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = 64'd0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Successive square roots of 2.0 in Q2.30.
  function automatic root_tab_t exp_roots();
    logic [63:0] r;
    root_tab_t   t;
    r = 64'd2 << 30;
    for (int k = 0; k < FRAC_BITS; k++) begin
      r    = isqrt64(r << 30);
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

`default_nettype wire

// File: hw/rtl/sths_mul.sv
// Shared magnitude multiplier of the height scaler back end, one registered product.
// Depends on sths_pkg.
`default_nettype none

module sths_mul (
  input  wire                clk_i,
  input  sths_pkg::mul_req_t req_i,
  output sths_pkg::mul_rsp_t rsp_o
);

  sths_pkg::mul_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    rsp_q.prod <= sths_pkg::PROD_W'(req_i.a_mag) * sths_pkg::PROD_W'(req_i.b_mag);
    rsp_q.neg  <= req_i.neg;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// File: hw/rtl/sths_front.sv
// Front end of the height scaler: takes requests and classifies them by mode and sign.
// Depends on sths_pkg.
`default_nettype none

module sths_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  sths_pkg::in_item_t in_item_i,
  input  wire [1:0]          mode_i,
  output logic               push_o,
  input  wire                push_ready_i,
  output sths_pkg::qent_t    push_data_o
);

  logic            valid_q, valid_d;
  sths_pkg::qent_t ent_q, ent_d;
  sths_pkg::cls_e  cls;
  logic            take;

  always_comb begin
    unique case (mode_i)
      sths_pkg::MODE_LOG:  cls = (in_item_i.sample_value <= 0) ? sths_pkg::CLS_LOW
                                                               : sths_pkg::CLS_LOG;
      sths_pkg::MODE_SKEW: cls = sths_pkg::CLS_SKEW;
      default:             cls = sths_pkg::CLS_PASS;
    endcase
  end

  assign in_stall_o = valid_q && !push_ready_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && push_ready_i;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (push_o) valid_d = 1'b0;
    if (take) begin
      valid_d       = 1'b1;
      ent_d.sample  = in_item_i.sample_value;
      ent_d.restart = in_item_i.restart;
      ent_d.cls     = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign push_data_o = ent_q;

endmodule

`default_nettype wire

// File: hw/rtl/sths_queue.sv
// Short request queue between front and back end of the height scaler.
// Depends on sths_pkg.
`default_nettype none

module sths_queue #(
  parameter int unsigned DEPTH = sths_pkg::QUEUE_DEPTH
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  output logic            push_ready_o,
  input  sths_pkg::qent_t push_data_i,
  input  wire             pop_i,
  output logic            pop_valid_o,
  output sths_pkg::qent_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sths_pkg::qent_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/sths_engine.sv
// Back end of the height scaler: sequencer for log, exp and the height map on one
// shared multiplier, running extents and the result register. Depends on sths_pkg, sths_mul.
`default_nettype none

module sths_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sths_pkg::cfg_t      cfg_i,
  input  wire                 pop_valid_i,
  output logic                pop_o,
  input  sths_pkg::qent_t     pop_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output sths_pkg::out_item_t out_item_o
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_SK_A   = 20'h00002,
    S_SK_B   = 20'h00004,
    S_SK_C   = 20'h00008,
    S_SK_D   = 20'h00010,
    S_SK_E   = 20'h00020,
    S_SK_F   = 20'h00040,
    S_EXP    = 20'h00080,
    S_EXP_W  = 20'h00100,
    S_EXP_SH = 20'h00200,
    S_SK_G   = 20'h00400,
    S_SK_H   = 20'h00800,
    S_NORM   = 20'h01000,
    S_LSQ    = 20'h02000,
    S_LSQ_W  = 20'h04000,
    S_LOGM   = 20'h08000,
    S_LOGR   = 20'h10000,
    S_HMUL   = 20'h20000,
    S_HADD   = 20'h40000,
    S_OUT    = 20'h80000
  } state_e;

  localparam int unsigned DW = sths_pkg::DATA_WIDTH;
  localparam int unsigned FB = sths_pkg::FRAC_BITS;
  localparam int unsigned SW = sths_pkg::SPROD_W;

  state_e                                 state_q, state_d;
  sths_pkg::val_t                         acc_q, acc_d;
  logic [DW-1:0]                          m_q, m_d;
  logic [FB-1:0]                          frac_q, frac_d;
  logic signed [sths_pkg::EXP_N_W-1:0]    n_q, n_d;
  logic [sths_pkg::CNT_W-1:0]             cnt_q, cnt_d;
  logic                                   restart_q, restart_d;
  logic                                   out_valid_q, out_valid_d;
  sths_pkg::out_item_t                    out_q, out_d;
  sths_pkg::val_t                         min_q, min_d, max_q, max_d;

  sths_pkg::mul_req_t                     req;
  sths_pkg::mul_rsp_t                     rsp;
  sths_pkg::val_t                         prodq, l2, uclip, ev, h;
  logic signed [SW-1:0]                   sp, wv, lr;
  logic [DW-1:0]                          sq;
  logic [63:0]                            wide;
  logic signed [sths_pkg::EXP_N_W:0]      sh;
  logic [sths_pkg::EXP_N_W-1:0]           nsh;
  logic                                   last;
  sths_pkg::val_t                         bmin, bmax;

  sths_mul u_mul (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign prodq = sths_pkg::mulq(rsp);
  assign sp    = sths_pkg::sprod(rsp);
  assign wv    = sp >>> 30;
  assign lr    = (sp + (SW'(1) <<< 31)) >>> 32;
  assign sq    = DW'(rsp.prod >> 30);
  assign last  = (cnt_q == sths_pkg::CNT_W'(FB - 1));
  assign l2    = ((sths_pkg::val_t'(n_q) - sths_pkg::val_t'(FB)) <<< FB)
               + sths_pkg::val_t'(frac_q);
  assign uclip = (prodq > sths_pkg::EXP_LIM) ? sths_pkg::EXP_LIM :
                 (prodq < -sths_pkg::EXP_LIM) ? -sths_pkg::EXP_LIM : prodq;
  assign sh    = (sths_pkg::EXP_N_W + 1)'(n_q) + (sths_pkg::EXP_N_W + 1)'(signed'(FB) - 30);
  assign nsh   = sths_pkg::EXP_N_W'(-sh);
  assign h     = sths_pkg::sat_add(prodq, cfg_i.height_offset);

  always_comb begin
    wide = 64'(m_q) << sh[5:0];
    if (!sh[sths_pkg::EXP_N_W]) begin
      if (sh >= 33)                          ev = sths_pkg::VAL_MAX;
      else if (wide > 64'(sths_pkg::VAL_MAX)) ev = sths_pkg::VAL_MAX;
      else                                   ev = sths_pkg::val_t'(wide);
    end else begin
      ev = sths_pkg::val_t'(m_q >> nsh);
    end
  end

  always_comb begin
    req = '0;
    unique case (state_q)
      S_SK_A: req = sths_pkg::sreq(acc_q, cfg_i.range_inverse);
      S_SK_C: req = sths_pkg::sreq(acc_q, cfg_i.skew_log);
      S_SK_E: begin
        req.a_mag = sths_pkg::mag(acc_q);
        req.b_mag = sths_pkg::MAG_W'(sths_pkg::LOG2E_Q30);
        req.neg   = acc_q[DW-1];
      end
      S_EXP: begin
        req.a_mag = sths_pkg::MAG_W'(m_q);
        req.b_mag = sths_pkg::MAG_W'(sths_pkg::EXP_ROOT[cnt_q[sths_pkg::FB_IDX_W-1:0]]);
      end
      S_SK_G: req = sths_pkg::sreq(cfg_i.skew_gain, acc_q);
      S_LSQ: begin
        req.a_mag = sths_pkg::MAG_W'(m_q);
        req.b_mag = sths_pkg::MAG_W'(m_q);
      end
      S_LOGM: begin
        req.a_mag = sths_pkg::mag(l2);
        req.b_mag = sths_pkg::MAG_W'(sths_pkg::LOG10_2_Q32);
        req.neg   = l2[DW-1];
      end
      S_HMUL: req = sths_pkg::sreq(cfg_i.height_gain, acc_q);
      default: req = '0;
    endcase
  end

  always_comb begin
    bmin = restart_q ? sths_pkg::VAL_MAX : min_q;
    bmax = restart_q ? sths_pkg::VAL_MIN : max_q;
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    m_d         = m_q;
    frac_d      = frac_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    min_d       = min_q;
    max_d       = max_q;
    pop_o       = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          pop_o     = 1'b1;
          restart_d = pop_data_i.restart;
          cnt_d     = '0;
          unique case (pop_data_i.cls)
            sths_pkg::CLS_LOW: begin
              acc_d   = cfg_i.range_low;
              state_d = S_HMUL;
            end
            sths_pkg::CLS_LOG: begin
              m_d     = pop_data_i.sample;
              state_d = S_NORM;
            end
            sths_pkg::CLS_SKEW: begin
              acc_d   = sths_pkg::sat_sub(pop_data_i.sample, cfg_i.range_low);
              state_d = S_SK_A;
            end
            default: begin
              acc_d   = pop_data_i.sample;
              state_d = S_HMUL;
            end
          endcase
        end
      end
      S_SK_A: state_d = S_SK_B;
      S_SK_B: begin
        acc_d   = prodq;
        state_d = S_SK_C;
      end
      S_SK_C: state_d = S_SK_D;
      S_SK_D: begin
        acc_d   = uclip;
        state_d = S_SK_E;
      end
      S_SK_E: state_d = S_SK_F;
      S_SK_F: begin
        n_d     = wv[FB +: sths_pkg::EXP_N_W];
        frac_d  = wv[FB-1:0];
        m_d     = sths_pkg::Q30_ONE;
        cnt_d   = '0;
        state_d = S_EXP;
      end
      S_EXP: state_d = S_EXP_W;
      S_EXP_W: begin
        if (frac_q[FB-1]) m_d = DW'(rsp.prod >> 30);
        frac_d  = frac_q << 1;
        cnt_d   = cnt_q + 1'b1;
        state_d = last ? S_EXP_SH : S_EXP;
      end
      S_EXP_SH: begin
        acc_d   = sths_pkg::sat_sub(ev, sths_pkg::Q_ONE);
        state_d = S_SK_G;
      end
      S_SK_G: state_d = S_SK_H;
      S_SK_H: begin
        acc_d   = sths_pkg::sat_add(prodq, cfg_i.range_low);
        state_d = S_HMUL;
      end
      S_NORM: begin
        if (m_q[sths_pkg::MANT_MSB]) begin
          n_d     = sths_pkg::EXP_N_W'(sths_pkg::MANT_MSB) - sths_pkg::EXP_N_W'(cnt_q);
          cnt_d   = '0;
          frac_d  = '0;
          state_d = S_LSQ;
        end else begin
          m_d   = m_q << 1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LSQ: state_d = S_LSQ_W;
      S_LSQ_W: begin
        m_d     = sq[DW-1] ? (sq >> 1) : sq;
        frac_d  = {frac_q[FB-2:0], sq[DW-1]};
        cnt_d   = cnt_q + 1'b1;
        state_d = last ? S_LOGM : S_LSQ;
      end
      S_LOGM: state_d = S_LOGR;
      S_LOGR: begin
        acc_d   = sths_pkg::val_t'(lr);
        state_d = S_HMUL;
      end
      S_HMUL: state_d = S_HADD;
      S_HADD: begin
        acc_d   = h;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          min_d            = (acc_q < bmin) ? acc_q : bmin;
          max_d            = (acc_q > bmax) ? acc_q : bmax;
          out_d.height     = acc_q;
          out_d.height_min = min_d;
          out_d.height_max = max_d;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      min_q       <= sths_pkg::VAL_MAX;
      max_q       <= sths_pkg::VAL_MIN;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    m_q       <= m_d;
    frac_q    <= frac_d;
    n_q       <= n_d;
    cnt_q     <= cnt_d;
    restart_q <= restart_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/scalar_to_height_scaler.sv
// Top level of the scalar-to-height scaler: configuration registers, front end,
// request queue and back end. Depends on sths_pkg, sths_front, sths_queue, sths_engine.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o  | in_item_i  (sample, restart)
//   output   | out_valid_o / out_stall_i| out_item_o (height, min, max)
//   config   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// The back end takes a new request only once done with the last. Linear mode and log
// of a non-positive sample go straight to the height map; log normalises the sample
// by shifts, then squares it once per fraction bit; skew takes one exponent step per
// fraction bit, all on the shared multiplier.
// Reset clears the extents, queue and handshake state; no clearing pass.
// Front and queue keep taking requests while back end or output stalls, until full.
`default_nettype none

module scalar_to_height_scaler #(
  parameter int unsigned QUEUE_DEPTH = sths_pkg::QUEUE_DEPTH
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  sths_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output sths_pkg::out_item_t               out_item_o,
  input  wire                               cfg_we_i,
  input  wire [sths_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [sths_pkg::DATA_WIDTH-1:0]    cfg_data_i
);

  sths_pkg::cfg_t  cfg_q, cfg_d;
  logic            push, push_ready, pop, pop_valid;
  sths_pkg::qent_t push_data, pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sths_pkg::CFG_MODE:    cfg_d.scaling_mode  = cfg_data_i[1:0];
        sths_pkg::CFG_LOW:     cfg_d.range_low     = cfg_data_i;
        sths_pkg::CFG_INVERSE: cfg_d.range_inverse = cfg_data_i;
        sths_pkg::CFG_SKEWLOG: cfg_d.skew_log      = cfg_data_i;
        sths_pkg::CFG_SKEWGN:  cfg_d.skew_gain     = cfg_data_i;
        sths_pkg::CFG_GAIN:    cfg_d.height_gain   = cfg_data_i;
        sths_pkg::CFG_OFFSET:  cfg_d.height_offset = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scaling_mode  <= sths_pkg::MODE_LINEAR;
      cfg_q.range_low     <= '0;
      cfg_q.range_inverse <= sths_pkg::Q_ONE;
      cfg_q.skew_log      <= '0;
      cfg_q.skew_gain     <= '0;
      cfg_q.height_gain   <= sths_pkg::Q_ONE;
      cfg_q.height_offset <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sths_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .mode_i       (cfg_q.scaling_mode),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sths_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  sths_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sths_checker.sv
// Port-level checker of the height scaler and its bind to the top level.
// Depends on sths_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sths_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input sths_pkg::out_item_t out_item_o
);

  `STHS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "busy in reset")

  `STHS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "result dropped under stall")

  `STHS_ASSERT(a_min_le, clk_i, rst_ni, out_valid_o |-> out_item_o.height_min <= out_item_o.height, "minimum above height")

  `STHS_ASSERT(a_max_ge, clk_i, rst_ni, out_valid_o |-> out_item_o.height_max >= out_item_o.height, "maximum below height")

endmodule

bind scalar_to_height_scaler sths_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// File: dv/sths_checker.sv
`timescale 1ns / 1ps
// Checker for the scalar-to-height scaler: mirrors the register file, predicts each
// height and its running extents, and compares them with the output channel. Uses sths_pkg.
module tb_sths_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  sths_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  sths_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [sths_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sths_pkg::DATA_WIDTH-1:0] cfg_data_i,
  output int                              mismatches,
  output int                              outstanding
);

  localparam longint TOP     = 64'sd2147483647;
  localparam longint BOTTOM  = -64'sd2147483648;
  localparam longint ONE_Q   = 64'sd65536;
  localparam longint K_L10_2 = 64'sd1292913987;
  localparam longint K_LOG2E = 64'sd1549082005;

  logic [1:0]          mode;
  longint              low, inv, slog, sgain, gain, offs, lo_ext, hi_ext;
  sths_pkg::out_item_t heights_q[$];

  function automatic longint clamp(longint v);
    return v > TOP ? TOP : (v < BOTTOM ? BOTTOM : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp(p < 0 ? -((-p) >>> 16) : p >>> 16);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic longint log10_q(longint x);
    longint unsigned m;
    longint          fr, l2;
    int              msb;
    msb = 0;
    for (int i = 0; i < 32; i++) if (x[i]) msb = i;
    m  = msb >= 30 ? longint'(x) >> (msb - 30) : longint'(x) << (30 - msb);
    fr = 0;
    for (int k = 0; k < 16; k++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        fr = fr | 1;
        m  = m >> 1;
      end
    end
    l2 = longint'(msb - 16) * ONE_Q + fr;
    return clamp((l2 * K_L10_2 + (64'sd1 <<< 31)) >>> 32);
  endfunction

  function automatic longint exp_q(longint u);
    longint          w, n, f, sh;
    longint unsigned acc, rt, v;
    if (u > 64 * ONE_Q) u = 64 * ONE_Q;
    if (u < -64 * ONE_Q) u = -64 * ONE_Q;
    w   = (u * K_LOG2E) >>> 30;
    n   = w >>> 16;
    f   = w - n * ONE_Q;
    acc = 64'd1 << 30;
    rt  = 64'd2 << 30;
    for (int k = 1; k <= 16; k++) begin
      rt = root_floor(rt << 30);
      if (f[16-k]) acc = (acc * rt) >> 30;
    end
    sh = n - 14;
    if (sh >= 0) begin
      if (sh >= 33) return TOP;
      v = acc << sh;
      return v > TOP ? TOP : longint'(v);
    end
    if (-sh >= 63) return 0;
    return longint'(acc >> (-sh));
  endfunction

  function automatic longint scale_sample(longint x);
    longint z;
    z = x;
    if (mode == sths_pkg::MODE_LOG) begin
      z = x <= 0 ? low : log10_q(x);
    end else if (mode == sths_pkg::MODE_SKEW) begin
      z = qmul(qmul(clamp(x - low), inv), slog);
      z = clamp(qmul(sgain, clamp(exp_q(z) - ONE_Q)) + low);
    end
    return clamp(qmul(gain, z) + offs);
  endfunction

  assign outstanding = heights_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint              h;
    int                  errs;
    sths_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      mode       <= sths_pkg::MODE_LINEAR;
      low        = 0;
      inv        = ONE_Q;
      slog       = 0;
      sgain      = 0;
      gain       = ONE_Q;
      offs       = 0;
      lo_ext     = TOP;
      hi_ext     = BOTTOM;
      mismatches <= 0;
      heights_q.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sths_pkg::CFG_MODE:    mode <= cfg_data_i[1:0];
          sths_pkg::CFG_LOW:     low = longint'($signed(cfg_data_i));
          sths_pkg::CFG_INVERSE: inv = longint'($signed(cfg_data_i));
          sths_pkg::CFG_SKEWLOG: slog = longint'($signed(cfg_data_i));
          sths_pkg::CFG_SKEWGN:  sgain = longint'($signed(cfg_data_i));
          sths_pkg::CFG_GAIN:    gain = longint'($signed(cfg_data_i));
          sths_pkg::CFG_OFFSET:  offs = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_item_i.restart) begin
          lo_ext = TOP;
          hi_ext = BOTTOM;
        end
        h = scale_sample(longint'(in_item_i.sample_value));
        if (h < lo_ext) lo_ext = h;
        if (h > hi_ext) hi_ext = h;
        exp_item.height     = h[31:0];
        exp_item.height_min = lo_ext[31:0];
        exp_item.height_max = hi_ext[31:0];
        heights_q.push_back(exp_item);
      end
      if (out_valid_o && !out_stall_i) begin
        if (heights_q.size() == 0) begin
          $error("unexpected result %h", out_item_o);
          errs++;
        end else begin
          exp_item = heights_q.pop_front();
          if (out_item_o.height !== exp_item.height) begin
            $error("height: expected %h actual %h", exp_item.height, out_item_o.height);
            errs++;
          end
          if (out_item_o.height_min !== exp_item.height_min) begin
            $error("height_min: expected %h actual %h",
                   exp_item.height_min, out_item_o.height_min);
            errs++;
          end
          if (out_item_o.height_max !== exp_item.height_max) begin
            $error("height_max: expected %h actual %h",
                   exp_item.height_max, out_item_o.height_max);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the height scaler testbench: clock, reset, register writes, sample stimulus
// and verdict. Depends on sths_pkg, scalar_to_height_scaler and tb_sths_checker.
module tb_top;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int         DOG_LIMIT  = 20000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  sths_pkg::in_item_t              in_item_i;
  sths_pkg::out_item_t             out_item_o;
  logic                            cfg_we_i;
  logic [sths_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sths_pkg::DATA_WIDTH-1:0] cfg_data_i;
  int                              mismatches, outstanding;
  int                              send_idle, recv_idle, quiet;

  always #5 clk_i = ~clk_i;

  scalar_to_height_scaler uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  tb_sths_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatches, .outstanding
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet <= 0;
    end else if (quiet >= DOG_LIMIT) begin
      $display("scalar_to_height_scaler: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(input logic [31:0] sample, input logic restart);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_item_i.sample_value <= sample;
    in_item_i.restart      <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [sths_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(6))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 524288)) - 32'd262144;
      3: return 32'($urandom_range(0, 8192));
      4: return 32'h00010000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= sths_pkg::CFG_MODE;
    cfg_data_i  <= '0;
    out_stall_i <= 1'b0;
    quiet       <= 0;
    send_idle   = 29;
    recv_idle   = 87;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(32'h7fffffff, 1'b1);
    send(32'h80000000, 1'b0);
    send(32'h00000000, 1'b0);
    send(32'hffffffff, 1'b1);
    drain();
    write_reg(sths_pkg::CFG_GAIN, 32'h7fffffff);
    write_reg(sths_pkg::CFG_OFFSET, 32'h80000000);
    send(32'h7fffffff, 1'b1);
    send(32'hffff0000, 1'b0);
    drain();
    write_reg(sths_pkg::CFG_GAIN, 32'h00010000);
    write_reg(sths_pkg::CFG_OFFSET, 32'h0);
    write_reg(sths_pkg::CFG_MODE, sths_pkg::MODE_LOG);
    write_reg(sths_pkg::CFG_LOW, 32'hfffb0000);
    send(32'h00000001, 1'b1);
    send(32'h7fffffff, 1'b0);
    send(32'h00000000, 1'b0);
    send(32'h80000000, 1'b0);
    send(32'h000a0000, 1'b0);
    drain();
    write_reg(sths_pkg::CFG_MODE, sths_pkg::MODE_SKEW);
    write_reg(sths_pkg::CFG_LOW, 32'h0);
    write_reg(sths_pkg::CFG_INVERSE, 32'd655);
    write_reg(sths_pkg::CFG_SKEWLOG, 32'd150902);
    write_reg(sths_pkg::CFG_SKEWGN, 32'd728177);
    send(32'h00000000, 1'b1);
    send(32'h00320000, 1'b0);
    send(32'h00640000, 1'b0);
    send(32'h80000000, 1'b0);
    send(32'h7fffffff, 1'b0);
    drain();
    write_reg(sths_pkg::CFG_INVERSE, 32'h7fffffff);
    write_reg(sths_pkg::CFG_SKEWLOG, 32'h7fffffff);
    send(32'h00010000, 1'b1);
    send(32'hffff0000, 1'b0);
    drain();
    write_reg(sths_pkg::CFG_MODE, MODE_UNDEF);
    send(32'h00050000, 1'b1);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      send_idle = ph < 3 ? 29 : (ph < 6 ? 87 : 0);
      recv_idle = ph < 3 ? 87 : (ph < 6 ? 29 : 0);
      m = 2'(ph % 4);
      write_reg(sths_pkg::CFG_MODE, m);
      write_reg(sths_pkg::CFG_LOW, pick_value());
      write_reg(sths_pkg::CFG_INVERSE, pick_value());
      write_reg(sths_pkg::CFG_SKEWLOG, pick_value());
      write_reg(sths_pkg::CFG_SKEWGN, pick_value());
      write_reg(sths_pkg::CFG_GAIN, $urandom_range(1) ? 32'h00010000 : pick_value());
      write_reg(sths_pkg::CFG_OFFSET, pick_value());
      for (int i = 0; i < 104; i++) begin
        send(pick_value(), $urandom_range(9) == 0);
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("scalar_to_height_scaler: match");
    end else begin
      $display("scalar_to_height_scaler: mismatch");
    end
    $finish;
  end

endmodule
